FILE: src/arq_pkg.sv
// Package for the array range query engine.
// Holds sizes, operation and status codes, beat structs and the sequencer states.
// No dependencies.
package arq_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = 9;
  localparam int VAL_W  = 32;
  localparam int RES_W  = 40;

  localparam logic [2:0] OP_SUM = 3'd0;
  localparam logic [2:0] OP_MAX = 3'd1;
  localparam logic [2:0] OP_SET = 3'd2;
  localparam logic [2:0] OP_ADD = 3'd3;
  localparam logic [2:0] OP_INS = 3'd4;
  localparam logic [2:0] OP_ERA = 3'd5;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_PUT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]              operation;
    logic [IDX_W-1:0]        start_index;
    logic [IDX_W-1:0]        stop_index;
    logic signed [VAL_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic [1:0]              status;
  } out_beat_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
  } mem_req_t;

endpackage

FILE: src/arq_store.sv
// Entry store: one write port, one registered read port, per-entry valid bits.
// An entry never written since reset reads as zero. Depends on arq_pkg.
module arq_store import arq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mem_req_t         req,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] entries_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [VAL_W-1:0] rd_data_r;
  logic             rd_hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      entries_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= entries_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_data_r : '0;

endmodule

FILE: src/arq_alu.sv
// Shared arithmetic unit: one 40-bit adder and one signed compare.
// Serves running sums, running maximum and wrapped range adds. Depends on arq_pkg.
module arq_alu import arq_pkg::*; (
  input  logic [2:0]              op,
  input  logic signed [RES_W-1:0] acc,
  input  logic [VAL_W-1:0]        entry,
  input  logic [VAL_W-1:0]        operand,
  output logic signed [RES_W-1:0] y
);

  logic signed [RES_W-1:0] ext_e;
  logic signed [RES_W-1:0] ext_v;
  logic signed [RES_W-1:0] add_a;
  logic signed [RES_W-1:0] add_b;
  logic signed [RES_W-1:0] sum;

  always_comb begin
    ext_e = {{(RES_W-VAL_W){entry[VAL_W-1]}}, entry};
    ext_v = {{(RES_W-VAL_W){operand[VAL_W-1]}}, operand};
    add_a = (op == OP_ADD) ? ext_e : acc;
    add_b = (op == OP_ADD) ? ext_v : ext_e;
    sum   = add_a + add_b;
    case (op)
      OP_SUM:  y = sum;
      OP_ADD:  y = sum;
      OP_MAX:  y = (ext_e > acc) ? ext_e : acc;
      default: y = ext_e;
    endcase
  end

endmodule

FILE: src/arq_seq.sv
// Sequencer: checks a request, then walks the entries one at a time.
// Drives the store and the shared unit and holds the length. Depends on arq_pkg.
module arq_seq import arq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  in_beat_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output out_beat_t               out_data,
  output mem_req_t                req,
  input  logic [VAL_W-1:0]        rd_data,
  output logic [2:0]              alu_op,
  output logic signed [RES_W-1:0] alu_acc,
  output logic [VAL_W-1:0]        alu_operand,
  input  logic signed [RES_W-1:0] alu_y
);

  seq_state_t state_r, state_nxt;
  logic [2:0]              op_r, op_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        end_r, end_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic signed [RES_W-1:0] acc_r, acc_nxt;
  status_t                 status_r, status_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  logic             accept;
  logic             range_ok;
  status_t          chk_status;
  seq_state_t       start_state;
  logic [IDX_W-1:0] k0, end0;
  logic [LEN_W-1:0] len0;
  logic [IDX_W-1:0] lo, hi, len_i;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] k_inc, k_dec;
  logic             can_emit;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign can_emit  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign k_inc     = k_r + 1'b1;
  assign k_dec     = k_r - 1'b1;

  always_comb begin
    lo          = in_data.start_index;
    hi          = in_data.stop_index;
    len_i       = IDX_W'(len_r);
    range_ok    = (lo <= hi) && (hi <= len_i);
    chk_status  = ST_OK;
    start_state = S_DONE;
    k0          = lo;
    end0        = hi;
    len0        = len_r;
    case (in_data.operation)
      OP_SUM, OP_MAX, OP_ADD: begin
        if (!range_ok) begin
          chk_status = ST_RANGE;
        end else if (lo != hi) begin
          start_state = S_RD;
        end
      end
      OP_SET: begin
        if (!range_ok) begin
          chk_status = ST_RANGE;
        end else if (lo != hi) begin
          start_state = S_PUT;
        end
      end
      OP_INS: begin
        end0 = lo + 1'b1;
        if (lo > len_i) begin
          chk_status = ST_RANGE;
        end else if (len_r == LEN_W'(DEPTH)) begin
          chk_status = ST_FULL;
        end else begin
          len0 = len_r + 1'b1;
          if (lo == len_i) begin
            start_state = S_PUT;
          end else begin
            start_state = S_RD;
            k0          = len_i;
          end
        end
      end
      OP_ERA: begin
        end0 = len_i - 1'b1;
        if (lo >= len_i) begin
          chk_status = ST_RANGE;
        end else begin
          len0 = len_r - 1'b1;
          if (lo + 1'b1 != len_i) begin
            start_state = S_RD;
          end
        end
      end
      default: chk_status = ST_RANGE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = start_state;
        end
      end
      S_RD: state_nxt = S_EX;
      S_EX: begin
        if (op_r == OP_INS) begin
          state_nxt = (k_r == end_r) ? S_PUT : S_RD;
        end else begin
          state_nxt = (k_inc == end_r) ? S_DONE : S_RD;
        end
      end
      S_PUT:   state_nxt = (k_inc == end_r) ? S_DONE : S_PUT;
      S_DONE: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt        = op_r;
    k_nxt         = k_r;
    end_nxt       = end_r;
    val_nxt       = val_r;
    acc_nxt       = acc_r;
    status_nxt    = status_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    req           = '0;
    case (op_r)
      OP_INS:  rd_idx = k_dec;
      OP_ERA:  rd_idx = k_inc;
      default: rd_idx = k_r;
    endcase
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_data.operation;
          k_nxt      = k0;
          end_nxt    = end0;
          val_nxt    = in_data.value;
          acc_nxt    = '0;
          status_nxt = chk_status;
          len_nxt    = len0;
        end
      end
      S_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = rd_idx[ADDR_W-1:0];
      end
      S_EX: begin
        req.wr_addr = k_r[ADDR_W-1:0];
        case (op_r)
          OP_SUM, OP_MAX: acc_nxt = alu_y;
          OP_ADD: begin
            req.wr_en   = 1'b1;
            req.wr_data = alu_y[VAL_W-1:0];
          end
          default: begin
            req.wr_en   = 1'b1;
            req.wr_data = rd_data;
          end
        endcase
        k_nxt = (op_r == OP_INS) ? k_dec : k_inc;
      end
      S_PUT: begin
        req.wr_en   = 1'b1;
        req.wr_addr = k_r[ADDR_W-1:0];
        req.wr_data = val_r;
        k_nxt       = k_inc;
      end
      S_DONE: begin
        if (can_emit) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.result = acc_r;
          out_data_nxt.status = status_r;
        end
      end
      default: ;
    endcase
  end

  assign alu_op      = op_r;
  assign alu_acc     = acc_r;
  assign alu_operand = val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    end_r      <= end_nxt;
    val_r      <= val_nxt;
    acc_r      <= acc_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: src/array_range_query_engine.sv
// Top level of the array range query engine.
// Depends on arq_pkg, arq_store, arq_alu and arq_seq.
//
// Usage:
// A request beat on in_data (operation, start_index, stop_index, value) is taken
// when in_valid is high and in_stall is low. Each request gives exactly one
// result beat on out_data (result, status), taken when out_valid is high and
// out_stall is low. One request is worked on at a time; in_stall stays high
// until its result has been loaded into the output register.
// Each entry that a request reads passes through a read state and then an
// execute state in the shared adder and compare unit; the single registered
// read port of the entry store sets this pace. Sum, max, add, insert and erase
// read their entries this way, one after another; set only writes its entries.
// A rejected request or an empty range goes straight to the done state. The
// result beat turns valid in the same cycle as in_stall drops.
// A finished result waits in the output register while out_stall is high, and
// the next request is accepted meanwhile; its result waits until the register
// frees. After reset all entries read as zero and the length is one.
module array_range_query_engine import arq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  mem_req_t                req;
  logic [VAL_W-1:0]        rd_data;
  logic [2:0]              alu_op;
  logic signed [RES_W-1:0] alu_acc;
  logic [VAL_W-1:0]        alu_operand;
  logic signed [RES_W-1:0] alu_y;

  arq_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  arq_alu u_alu (
    .op      (alu_op),
    .acc     (alu_acc),
    .entry   (rd_data),
    .operand (alu_operand),
    .y       (alu_y)
  );

  arq_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .req         (req),
    .rd_data     (rd_data),
    .alu_op      (alu_op),
    .alu_acc     (alu_acc),
    .alu_operand (alu_operand),
    .alu_y       (alu_y)
  );

endmodule
